>>> hdl/stk500_boot_loader_engine_defines.svh
// Assertion macros used by the boot loader engine top level.
`ifndef STK500_BOOT_LOADER_ENGINE_DEFINES_SVH
`define STK500_BOOT_LOADER_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define STKBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define STKBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/stkbl_pkg.sv
// Types and constants of the STK500 boot loader engine.
package stkbl_pkg;

  // Framing bytes
  localparam logic [7:0] EOP_BYTE    = 8'h20;
  localparam logic [7:0] INSYNC_BYTE = 8'h14;
  localparam logic [7:0] OK_BYTE     = 8'h10;

  // Command codes
  localparam logic [7:0] CMD_GET_PARAM  = 8'h41;
  localparam logic [7:0] CMD_SET_DEVICE = 8'h42;
  localparam logic [7:0] CMD_SET_DEV_EXT = 8'h45;
  localparam logic [7:0] CMD_LEAVE      = 8'h51;
  localparam logic [7:0] CMD_LOAD_ADDR  = 8'h55;
  localparam logic [7:0] CMD_UNIVERSAL  = 8'h56;
  localparam logic [7:0] CMD_PROG_PAGE  = 8'h64;
  localparam logic [7:0] CMD_READ_PAGE  = 8'h74;
  localparam logic [7:0] CMD_READ_SIG   = 8'h75;

  // Indicator patterns
  localparam logic [7:0] LED_GET_PARAM  = 8'h01;
  localparam logic [7:0] LED_READ_SIG   = 8'h02;
  localparam logic [7:0] LED_SET_DEVICE = 8'h04;
  localparam logic [7:0] LED_SET_DEV_EXT = 8'h08;
  localparam logic [7:0] LED_LOAD_ADDR  = 8'h10;
  localparam logic [7:0] LED_UNIVERSAL  = 8'h20;
  localparam logic [7:0] LED_READ_PAGE  = 8'h40;
  localparam logic [7:0] LED_PROG_PAGE  = 8'h80;
  localparam logic [7:0] LED_NONE       = 8'h00;

  // Parameter ids and fixed answers
  localparam logic [7:0] PARAM_MAJOR     = 8'h81;
  localparam logic [7:0] PARAM_MINOR     = 8'h82;
  localparam logic [7:0] PARAM_DEFAULT   = 8'h03;
  localparam logic [7:0] UNIVERSAL_REPLY = 8'h00;

  // Operand bytes skipped by the skipping commands
  localparam logic [4:0] SKIP_SET_DEVICE = 5'd20;
  localparam logic [4:0] SKIP_SET_DEV_EXT = 5'd5;
  localparam logic [4:0] SKIP_UNIVERSAL  = 5'd4;

  // Input item kinds
  localparam logic OP_RX_BYTE  = 1'b0;
  localparam logic OP_TX_READY = 1'b1;

  // Reply sequencer
  localparam int unsigned MAX_REPLY = 5;

  typedef enum logic [2:0] {
    CFG_SIG_FIRST  = 3'd0,
    CFG_SIG_SECOND = 3'd1,
    CFG_SIG_THIRD  = 3'd2,
    CFG_VER_MAJOR  = 3'd3,
    CFG_VER_MINOR  = 3'd4
  } stkbl_cfg_e;

  typedef enum logic [3:0] {
    PH_WAIT    = 4'd0,
    PH_PARAM   = 4'd1,
    PH_SKIP    = 4'd2,
    PH_ADDR_LO = 4'd3,
    PH_ADDR_HI = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_LEN_LO  = 4'd6,
    PH_MEMTYPE = 4'd7,
    PH_DATA    = 4'd8,
    PH_EOP     = 4'd9
  } stkbl_phase_e;

  // Access request towards the program store
  typedef struct packed {
    logic wr;
    logic rd;
  } stkbl_mem_cmd_t;

endpackage

>>> hdl/stkbl_store.sv
// Program store: single-port memory with registered read and a power-up fill sweep.
module stkbl_store import stkbl_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stkbl_mem_cmd_t cmd_i,
  input  logic [AW-1:0]  addr_i,
  input  logic [7:0]     wdata_i,
  output logic [7:0]     rdata_o,
  output logic           busy_o
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic          fill_q, fill_d;
  logic [AW-1:0] fill_cnt_q, fill_cnt_d;
  logic [7:0]    fill_val;

  // Entry i powers up holding (i+1) mod 256
  assign fill_val = 8'(32'(fill_cnt_q) + 32'd1);

  always_comb begin
    fill_d     = fill_q;
    fill_cnt_d = fill_cnt_q;
    if (fill_q) begin
      if (fill_cnt_q == AW'(DEPTH - 1)) begin
        fill_d = 1'b0;
      end else begin
        fill_cnt_d = fill_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= 1'b1;
      fill_cnt_q <= '0;
    end else begin
      fill_q     <= fill_d;
      fill_cnt_q <= fill_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_q) begin
      mem[fill_cnt_q] <= fill_val;
    end else if (cmd_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = fill_q;

endmodule

>>> hdl/stk500_boot_loader_engine.sv
// Top level of the STK500 boot loader engine: command parser, reply sequencer, store.
//
// Input stream (s_axis_*): one transaction per received byte or transmit-ready
// event. tuser is the item kind (0 received byte, 1 transmitter ready), tdata
// carries the received byte. Output stream (m_axis_*): one transaction per
// byte to send; tlast marks the final byte caused by one input item, tuser
// flags a missing end-of-packet on the in-sync byte, tdata[15:8] shows the
// indicator pattern of the last command.
// Latency: the first reply byte appears the cycle after the input is taken.
// Throughput: one input item per cycle for items with no or one reply byte
// while the receiver takes every byte; an item with n reply bytes is followed
// by the next input in the cycle its last byte is taken.
// The load address is reduced modulo STORE_DEPTH by reciprocal multiplication
// in quotient then remainder registers, before page commands read it; input not held.
// Reset: the program store is filled by a sweep over all STORE_DEPTH entries,
// one entry per cycle; no input is taken meanwhile, configuration writes are.
// A stalled receiver holds the current reply byte on the output and blocks
// the input once the reply sequencer is full; nothing is dropped.
// Configuration writes (cfg_we_i) are taken at any edge, with no read-back.
`include "stk500_boot_loader_engine_defines.svh"

module stk500_boot_loader_engine import stkbl_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_data
  input  logic        s_axis_tuser,   // [0] operation
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] tx_data, [15:8] led_pattern
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] sync_error
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  // Reciprocal of STORE_DEPTH scaled by 2^MS, exact for every 16-bit address
  localparam int unsigned MS = 16 + AW;
  localparam logic [17:0] MREC =
    18'(((64'd1 << MS) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH));

  // Configuration registers
  logic [7:0] sig0_q, sig1_q, sig2_q, vmaj_q, vmin_q;

  // Parser state
  stkbl_phase_e phase_q, phase_d;
  logic [7:0]   cmd_q, cmd_d;
  logic [4:0]   skip_q, skip_d;
  logic [15:0]  dcnt_q, dcnt_d;
  logic [15:0]  ldaddr_q, ldaddr_d;
  logic [15:0]  plen_q, plen_d;
  logic [7:0]   lenhi_q, lenhi_d;
  logic [7:0]   param_q, param_d;
  logic [15:0]  rdrem_q, rdrem_d;
  logic [7:0]   led_q, led_d;
  logic [AW-1:0] ptr_q, ptr_d, ptr_inc;

  // Address reduction unit
  logic [15:0]   mod_x_q;
  logic [16:0]   mod_quo_q, mod_quo_d;
  logic [33:0]   mod_prod, mod_back;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] base;

  // Reply sequencer
  logic       res_valid_q;
  logic [2:0] res_idx_q, res_n_q;
  logic [7:0] res_byte_q [MAX_REPLY];
  logic       res_err_q, res_mem_q;
  logic [7:0] res_led_q;
  logic       res_last, res_free;

  logic       new_res, new_err, new_mem;
  logic [2:0] new_n;
  logic [7:0] new_byte [MAX_REPLY];

  // Store interface
  stkbl_mem_cmd_t mem_cmd;
  logic [7:0]     mem_rdata;
  logic           fill_busy;

  logic       in_acc, op;
  logic [7:0] rxb;
  logic [7:0] param_val;

  assign op  = s_axis_tuser;
  assign rxb = s_axis_tdata;

  assign res_last = (res_idx_q == res_n_q - 3'd1);
  assign res_free = !res_valid_q || (m_axis_tready && res_last);

  assign s_axis_tready = !fill_busy && res_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign base    = base_q;
  assign ptr_inc = (ptr_q == AW'(STORE_DEPTH - 1)) ? '0 : ptr_q + AW'(1);

  always_comb begin
    if (param_q == PARAM_MINOR) begin
      param_val = vmin_q;
    end else if (param_q == PARAM_MAJOR) begin
      param_val = vmaj_q;
    end else begin
      param_val = PARAM_DEFAULT;
    end
  end

  // Configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig0_q <= 8'h1E;
      sig1_q <= 8'h95;
      sig2_q <= 8'h0F;
      vmaj_q <= 8'd19;
      vmin_q <= 8'd3;
    end else if (cfg_we_i) begin
      case (stkbl_cfg_e'(cfg_idx_i))
        CFG_SIG_FIRST:  sig0_q <= cfg_data_i;
        CFG_SIG_SECOND: sig1_q <= cfg_data_i;
        CFG_SIG_THIRD:  sig2_q <= cfg_data_i;
        CFG_VER_MAJOR:  vmaj_q <= cfg_data_i;
        CFG_VER_MINOR:  vmin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser: next state and reply set-up
  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    skip_d    = skip_q;
    dcnt_d    = dcnt_q;
    ldaddr_d  = ldaddr_q;
    plen_d    = plen_q;
    lenhi_d   = lenhi_q;
    param_d   = param_q;
    rdrem_d   = rdrem_q;
    led_d     = led_q;
    ptr_d     = ptr_q;
    mem_cmd   = '0;
    new_res   = 1'b0;
    new_err   = 1'b0;
    new_mem   = 1'b0;
    new_n     = 3'd0;
    for (int i = 0; i < MAX_REPLY; i++) begin
      new_byte[i] = '0;
    end

    if (in_acc) begin
      if (op == OP_TX_READY) begin
        // Readout: one stored byte, and ok after the final one
        if (rdrem_q != 16'd0) begin
          mem_cmd.rd  = 1'b1;
          ptr_d       = ptr_inc;
          rdrem_d     = rdrem_q - 16'd1;
          new_res     = 1'b1;
          new_mem     = 1'b1;
          new_byte[1] = OK_BYTE;
          new_n       = (rdrem_q == 16'd1) ? 3'd2 : 3'd1;
        end
      end else if (rdrem_q == 16'd0) begin
        case (phase_q)
          PH_WAIT: begin
            cmd_d   = rxb;
            phase_d = PH_EOP;
            case (rxb)
              CMD_GET_PARAM: begin
                led_d   = LED_GET_PARAM;
                phase_d = PH_PARAM;
              end
              CMD_READ_SIG: led_d = LED_READ_SIG;
              CMD_SET_DEVICE: begin
                led_d   = LED_SET_DEVICE;
                skip_d  = SKIP_SET_DEVICE;
                phase_d = PH_SKIP;
              end
              CMD_SET_DEV_EXT: begin
                led_d   = LED_SET_DEV_EXT;
                skip_d  = SKIP_SET_DEV_EXT;
                phase_d = PH_SKIP;
              end
              CMD_LOAD_ADDR: begin
                led_d   = LED_LOAD_ADDR;
                phase_d = PH_ADDR_LO;
              end
              CMD_UNIVERSAL: begin
                led_d   = LED_UNIVERSAL;
                skip_d  = SKIP_UNIVERSAL;
                phase_d = PH_SKIP;
              end
              CMD_READ_PAGE: begin
                led_d   = LED_READ_PAGE;
                phase_d = PH_LEN_HI;
              end
              CMD_PROG_PAGE: begin
                led_d   = LED_PROG_PAGE;
                phase_d = PH_LEN_HI;
              end
              CMD_LEAVE: ;
              default: led_d = LED_NONE;
            endcase
          end
          PH_PARAM: begin
            param_d = rxb;
            phase_d = PH_EOP;
          end
          PH_SKIP: begin
            skip_d = skip_q - 5'd1;
            if (skip_q == 5'd1) begin
              phase_d = PH_EOP;
            end
          end
          PH_ADDR_LO: begin
            ldaddr_d[7:0] = rxb;
            phase_d       = PH_ADDR_HI;
          end
          PH_ADDR_HI: begin
            ldaddr_d[15:8] = rxb;
            phase_d        = PH_EOP;
          end
          PH_LEN_HI: begin
            lenhi_d = rxb;
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            plen_d  = {lenhi_q, rxb};
            phase_d = PH_MEMTYPE;
          end
          PH_MEMTYPE: begin
            dcnt_d = '0;
            ptr_d  = base;
            if (cmd_q == CMD_PROG_PAGE && plen_q != 16'd0) begin
              phase_d = PH_DATA;
            end else begin
              phase_d = PH_EOP;
            end
          end
          PH_DATA: begin
            mem_cmd.wr = 1'b1;
            ptr_d      = ptr_inc;
            dcnt_d     = dcnt_q + 16'd1;
            if (dcnt_q + 16'd1 == plen_q) begin
              phase_d = PH_EOP;
            end
          end
          PH_EOP: begin
            phase_d     = PH_WAIT;
            new_res     = 1'b1;
            new_err     = (rxb != EOP_BYTE);
            new_byte[0] = INSYNC_BYTE;
            case (cmd_q)
              CMD_GET_PARAM: begin
                new_byte[1] = param_val;
                new_byte[2] = OK_BYTE;
                new_n       = 3'd3;
              end
              CMD_READ_SIG: begin
                new_byte[1] = sig0_q;
                new_byte[2] = sig1_q;
                new_byte[3] = sig2_q;
                new_byte[4] = OK_BYTE;
                new_n       = 3'd5;
              end
              CMD_UNIVERSAL: begin
                new_byte[1] = UNIVERSAL_REPLY;
                new_byte[2] = OK_BYTE;
                new_n       = 3'd3;
              end
              CMD_READ_PAGE: begin
                // Arm the readout; ok follows the final page byte, or the in-sync byte if the length is zero
                rdrem_d     = plen_q;
                ptr_d       = base;
                new_byte[1] = OK_BYTE;
                new_n       = (plen_q != 16'd0) ? 3'd1 : 3'd2;
              end
              default: begin
                new_byte[1] = OK_BYTE;
                new_n       = 3'd2;
              end
            endcase
          end
          default: phase_d = PH_WAIT;
        endcase
      end
    end
  end

  // Address reduction: quotient by reciprocal multiply, then remainder by
  // multiply-back and subtract, one register stage each
  assign mod_prod  = 34'(ldaddr_q) * 34'(MREC);
  assign mod_quo_d = 17'(mod_prod >> MS);
  assign mod_back  = 34'(mod_quo_q) * 34'(STORE_DEPTH);
  assign base_d    = AW'(34'(mod_x_q) - mod_back);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      cmd_q      <= '0;
      skip_q     <= '0;
      dcnt_q     <= '0;
      ldaddr_q   <= '0;
      plen_q     <= '0;
      lenhi_q    <= '0;
      param_q    <= '0;
      rdrem_q    <= '0;
      led_q      <= '0;
      ptr_q      <= '0;
      mod_x_q    <= '0;
      mod_quo_q  <= '0;
      base_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      cmd_q      <= cmd_d;
      skip_q     <= skip_d;
      dcnt_q     <= dcnt_d;
      ldaddr_q   <= ldaddr_d;
      plen_q     <= plen_d;
      lenhi_q    <= lenhi_d;
      param_q    <= param_d;
      rdrem_q    <= rdrem_d;
      led_q      <= led_d;
      ptr_q      <= ptr_d;
      mod_x_q    <= ldaddr_q;
      mod_quo_q  <= mod_quo_d;
      base_q     <= base_d;
    end
  end

  // Reply sequencer control: load a new reply, advance on each output transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_idx_q   <= '0;
      res_n_q     <= '0;
    end else if (new_res) begin
      res_valid_q <= 1'b1;
      res_idx_q   <= '0;
      res_n_q     <= new_n;
    end else if (res_valid_q && m_axis_tready) begin
      if (res_last) begin
        res_valid_q <= 1'b0;
      end else begin
        res_idx_q <= res_idx_q + 3'd1;
      end
    end
  end

  // Reply payload; the indicator is captured when the reply is set up
  always_ff @(posedge clk_i) begin
    if (new_res) begin
      res_byte_q <= new_byte;
      res_err_q  <= new_err;
      res_mem_q  <= new_mem;
      res_led_q  <= led_q;
    end
  end

  stkbl_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (mem_cmd),
    .addr_i  (ptr_q),
    .wdata_i (rxb),
    .rdata_o (mem_rdata),
    .busy_o  (fill_busy)
  );

  assign m_axis_tvalid      = res_valid_q;
  assign m_axis_tdata[7:0]  = (res_mem_q && res_idx_q == 3'd0) ? mem_rdata
                                                              : res_byte_q[res_idx_q];
  assign m_axis_tdata[15:8] = res_led_q;
  assign m_axis_tlast       = res_last;
  assign m_axis_tuser       = res_err_q && (res_idx_q == 3'd0);

  `STKBL_ASSERT_NOW(a_idx_in_range, res_valid_q, res_idx_q < res_n_q,
                    "reply index beyond reply length")
  `STKBL_ASSERT_NOW(a_no_write_in_readout, mem_cmd.wr, rdrem_q == 16'd0,
                    "store written while a readout is pending")
  `STKBL_ASSERT_NEXT(a_readout_reply, in_acc && op && rdrem_q != 16'd0,
                     res_valid_q && res_mem_q && res_idx_q == 3'd0,
                     "readout byte not presented after transmit-ready")

endmodule
